FILE: rtl/core/multiturn_pid_position_loop_assert.svh
// Assertion macros shared by the position loop RTL.
`ifndef MULTITURN_PID_POSITION_LOOP_ASSERT_SVH
`define MULTITURN_PID_POSITION_LOOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTPID_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MTPID_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/mtpid_pkg.sv
// Constants, widths and codes for the multiturn PID position loop.
package mtpid_pkg;

    localparam int REV_W    = 16;
    localparam int ENC_W    = 16;
    localparam int TGT_W    = 32;
    localparam int GAIN_W   = 16;
    localparam int LIMIT_W  = 16;
    localparam int ERR_W    = 34;
    localparam int DIFF_W   = ERR_W + 1;
    localparam int MUL_A_W  = 36;
    localparam int MUL_B_W  = GAIN_W + 1;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int ACC_W    = 54;
    localparam int INT_W    = 48;
    localparam int FRAC_W   = 8;
    localparam int MAG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 56;

    localparam logic [MUL_B_W-1:0] COUNTS_PER_WRAP = MUL_B_W'(56505);
    localparam int INTEGRAL_WINDOW = 100;
    localparam logic signed [ERR_W-1:0] WIN_HI = ERR_W'(INTEGRAL_WINDOW);
    localparam logic signed [ERR_W-1:0] WIN_LO = -WIN_HI;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4095);

    localparam logic signed [INT_W-1:0] INT_MAX = {1'b0, {(INT_W-1){1'b1}}};
    localparam logic signed [INT_W-1:0] INT_MIN = {1'b1, {(INT_W-1){1'b0}}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd3;

    // Request kinds carried in tuser
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_WRAP = 1'b1;

endpackage

FILE: rtl/core/multiturn_pid_position_loop.sv
// Top level of the multiturn PID position loop for one motor channel.
//
// Input stream (s_axis): one transaction per request. tuser selects a control
// tick or an encoder wrap event; a wrap event moves the signed revolution
// counter by one and produces no result. Output stream (m_axis): one transaction
// per control tick with drive magnitude, reverse flag and position error.
// Configuration: write i_cfg_we/i_cfg_index/i_cfg_data while the block is idle.
//
// Sequencing: a wrap event leaves the sequencer idle. A control tick runs
// through 9 sequencer steps after acceptance, built around one shared 36x17
// signed multiplier that forms rev*period, P, D and I products one after
// another, followed by integrator, sum and clamp steps. s_axis_tready is high
// only while the sequencer is idle.
//
// The result sits in an output register; the next request is accepted while it
// waits. If the receiver stalls, the following tick holds in its last step until
// the output register frees up. Synchronous active-low reset clears gains to
// zero, the drive limit to 4095, and the revolution count, previous error and
// integrator to zero.
module multiturn_pid_position_loop
    import mtpid_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [0] wrap_direction, [16:1] encoder_count, [48:17] target_position, rest zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] req_type
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [15:0] drive_magnitude, [16] drive_reverse, [50:17] position_error, rest zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [GAIN_W-1:0]     i_cfg_data
);

    // Sequencer steps
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_POS   = 4'd1;
    localparam logic [3:0] S_ERR   = 4'd2;
    localparam logic [3:0] S_P     = 4'd3;
    localparam logic [3:0] S_D     = 4'd4;
    localparam logic [3:0] S_I     = 4'd5;
    localparam logic [3:0] S_INT   = 4'd6;
    localparam logic [3:0] S_SUM   = 4'd7;
    localparam logic [3:0] S_CLAMP = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0]                r_state;
    logic [3:0]                n_state;

    logic signed [GAIN_W-1:0]  r_kp;
    logic signed [GAIN_W-1:0]  r_ki;
    logic signed [GAIN_W-1:0]  r_kd;
    logic [LIMIT_W-1:0]        r_limit;

    logic signed [REV_W-1:0]   r_rev;
    logic signed [ERR_W-1:0]   r_prev_err;
    logic signed [INT_W-1:0]   r_int;

    logic [ENC_W-1:0]          r_enc;
    logic signed [TGT_W-1:0]   r_target;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [DIFF_W-1:0]  r_diff;
    logic                      r_win;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;

    logic                      r_out_valid;
    logic [MAG_W-1:0]          r_out_mag;
    logic                      r_out_rev;
    logic signed [ERR_W-1:0]   r_out_err;

    logic                      in_fire;
    logic                      out_free;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [ERR_W-1:0]   n_err;
    logic signed [INT_W:0]     int_sum;
    logic signed [ACC_W-1:0]   lim;
    logic signed [ACC_W-1:0]   acc_abs;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - ERR_W - 1 - MAG_W){1'b0}},
                            r_out_err, r_out_rev, r_out_mag};

    // Shared multiplier operand select
    always_comb begin
        case (r_state)
            S_POS: begin
                mul_a = MUL_A_W'(r_rev);
                mul_b = $signed(COUNTS_PER_WRAP);
            end
            S_D: begin
                mul_a = MUL_A_W'(r_diff);
                mul_b = MUL_B_W'(r_kd);
            end
            S_I: begin
                mul_a = MUL_A_W'(r_err);
                mul_b = MUL_B_W'(r_ki);
            end
            default: begin
                mul_a = MUL_A_W'(r_err);
                mul_b = MUL_B_W'(r_kp);
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // error = target - (rev * period + encoder), kept modulo 2^34
    assign n_err = ERR_W'(r_target) - r_prod[ERR_W-1:0] - ERR_W'(r_enc);

    assign int_sum = (INT_W+1)'(r_int) + r_prod[INT_W:0];

    assign lim     = $signed({{(ACC_W - LIMIT_W - FRAC_W){1'b0}}, r_limit, {FRAC_W{1'b0}}});
    assign acc_abs = (r_acc <= 0) ? -r_acc : r_acc;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire && (s_axis_tuser == REQ_TICK)) begin
                    n_state = S_POS;
                end
            end
            S_POS:   n_state = S_ERR;
            S_ERR:   n_state = S_P;
            S_P:     n_state = S_D;
            S_D:     n_state = S_I;
            S_I:     n_state = S_INT;
            S_INT:   n_state = S_SUM;
            S_SUM:   n_state = S_CLAMP;
            S_CLAMP: n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state, configuration and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kp        <= '0;
            r_ki        <= '0;
            r_kd        <= '0;
            r_limit     <= LIMIT_RESET;
            r_rev       <= '0;
            r_prev_err  <= '0;
            r_int       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_KP:    r_kp    <= i_cfg_data;
                    CFG_KI:    r_ki    <= i_cfg_data;
                    CFG_KD:    r_kd    <= i_cfg_data;
                    CFG_LIMIT: r_limit <= i_cfg_data;
                    default:   ;
                endcase
            end

            // Wrap event: step the revolution counter, modulo 2^16
            if (in_fire && (s_axis_tuser == REQ_WRAP)) begin
                r_rev <= s_axis_tdata[0] ? r_rev - 16'sd1 : r_rev + 16'sd1;
            end

            if (r_state == S_P) begin
                r_prev_err <= r_err;
            end

            // Accumulate only inside the window, saturating to 48 bits
            if ((r_state == S_INT) && r_win) begin
                if (int_sum[INT_W] != int_sum[INT_W-1]) begin
                    r_int <= int_sum[INT_W] ? INT_MIN : INT_MAX;
                end else begin
                    r_int <= int_sum[INT_W-1:0];
                end
            end

            if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;

        if (in_fire) begin
            r_enc    <= s_axis_tdata[ENC_W:1];
            r_target <= s_axis_tdata[ENC_W+TGT_W:ENC_W+1];
        end

        case (r_state)
            S_ERR: r_err <= n_err;
            S_P: begin
                r_diff <= DIFF_W'(r_err) - DIFF_W'(r_prev_err);
                r_win  <= (r_err > WIN_LO) && (r_err < WIN_HI);
            end
            S_D:   r_acc <= ACC_W'(r_prod);
            S_I:   r_acc <= r_acc + ACC_W'(r_prod);
            S_SUM: r_acc <= r_acc + ACC_W'(r_int);
            S_CLAMP: begin
                if (r_acc > lim) begin
                    r_acc <= lim;
                end else if (r_acc < -lim) begin
                    r_acc <= -lim;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    r_out_rev <= (r_acc <= 0);
                    r_out_mag <= acc_abs[FRAC_W+MAG_W-1:FRAC_W];
                    r_out_err <= r_err;
                end
            end
            default: ;
        endcase
    end

`include "multiturn_pid_position_loop_assert.svh"

    // A wrap event moves the revolution count by exactly one and starts no work
    `MTPID_ASSERT_NEXT(a_wrap_step, i_clk, i_rst_n, in_fire && (s_axis_tuser == REQ_WRAP), (r_state == S_IDLE) && ((r_rev == $past(r_rev) + 16'sd1) || (r_rev == $past(r_rev) - 16'sd1)), "wrap event did not step the revolution count by one")

    // A control tick always enters the sequencer
    `MTPID_ASSERT_NEXT(a_tick_start, i_clk, i_rst_n, in_fire && (s_axis_tuser == REQ_TICK), r_state == S_POS, "control tick did not start the sequencer")

    // The value handed to the output stage lies within the drive limit
    `MTPID_ASSERT_NOW(a_clamp_range, i_clk, i_rst_n, r_state == S_OUT, (r_acc <= lim) && (r_acc >= -lim), "clamped sum outside the drive limit")

    // Finishing a tick always presents a result on the next cycle
    `MTPID_ASSERT_NEXT(a_result_shown, i_clk, i_rst_n, (r_state == S_OUT) && out_free, m_axis_tvalid && (r_state == S_IDLE), "finished tick did not present a result")

endmodule
